FILE: src/quaternion_orientation_unit_macros.svh
// Assertion shorthands, clocked on clk, idle during reset.
`ifndef QUATERNION_ORIENTATION_UNIT_MACROS_SVH
`define QUATERNION_ORIENTATION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define QOU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define QOU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define QOU_ASSERT_IMPL(label, ante, cons, msg)
`define QOU_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: src/qou_pkg.sv
`timescale 1ns / 1ps
package qou_pkg;
	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int QW = 32;
	localparam int AW = 36;
	localparam int BW = 34;
	localparam int ZW = 36;
	localparam int HW = 18;
	localparam int MW = HW + 1;
	localparam int PW = AW + BW;
	localparam int FRAC = 30;
	localparam int TW = PW - FRAC;
	localparam int SW = TW + 2;

	localparam logic signed [BW-1:0] CORDIC_GAIN = BW'(64'sd652032874);
	localparam logic signed [ZW-1:0] PI_Q30 = ZW'(64'sd3373259426);
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
	localparam logic signed [QW-1:0] Q30_ONE = QW'(64'sd1073741824);
	localparam logic signed [PW-1:0] ROUND_HALF = PW'(64'sd536870912);
	localparam logic signed [SW-1:0] SAT_HI = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sd2147483648);
	// bit k*4+j set: term j of Hamilton component k is subtracted
	localparam logic [15:0] HAM_MINUS = 16'h7214;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_APPLY = 2'd1,
		FUNC_ROT   = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEXT,
		ST_CORDIC,
		ST_HAM,
		ST_OUT
	} state_t;

	function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
		int n;
		n = int'(i);
		case (n)
			0: atan_entry = ZW'(64'sd843314856);
			1: atan_entry = ZW'(64'sd497837829);
			2: atan_entry = ZW'(64'sd263043836);
			3: atan_entry = ZW'(64'sd133525158);
			4: atan_entry = ZW'(64'sd67021686);
			5: atan_entry = ZW'(64'sd33543515);
			6: atan_entry = ZW'(64'sd16775850);
			7: atan_entry = ZW'(64'sd8388437);
			8: atan_entry = ZW'(64'sd4194282);
			9: atan_entry = ZW'(64'sd2097149);
			default: begin
				if (n <= FRAC)
					atan_entry = (ZW'(1) << (FRAC - n)) - ZW'(1);
				else
					atan_entry = '0;
			end
		endcase
	endfunction

	function automatic logic signed [QW-1:0] sat32(input logic signed [SW-1:0] v);
		if (v > SAT_HI)
			sat32 = SAT_HI[QW-1:0];
		else if (v < SAT_LO)
			sat32 = SAT_LO[QW-1:0];
		else
			sat32 = v[QW-1:0];
	endfunction
endpackage

FILE: src/qou_req_if.sv
`timescale 1ns / 1ps
interface qou_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic signed [31:0] arg_x;
	logic signed [31:0] arg_y;
	logic signed [31:0] arg_z;
	logic signed [31:0] angle;

	modport source(output valid, func, arg_x, arg_y, arg_z, angle, input ready);
	modport sink(input valid, func, arg_x, arg_y, arg_z, angle, output ready);
endinterface

FILE: src/qou_rsp_if.sv
`timescale 1ns / 1ps
interface qou_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] quat_x;
	logic signed [31:0] quat_y;
	logic signed [31:0] quat_z;
	logic signed [31:0] quat_w;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;

	modport source(output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
		input ready);
	modport sink(input valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
		output ready);
endinterface

FILE: src/quaternion_orientation_unit.sv
// Orientation quaternion unit (Q2.30 state, reset to identity). One word is taken at a time;
// ready is low until its result word has been taken. Every product runs on one shared
// 19x34-bit multiplier in two passes plus a rounding step; each sin/cos comes from an
// iterative CORDIC. A load runs one CORDIC and one Hamilton product, a rotate two Hamilton
// products, and pitch/yaw/roll one CORDIC and one Hamilton product per nonzero angle,
// skipping each zero angle.
`timescale 1ns / 1ps
`include "quaternion_orientation_unit_macros.svh"
module quaternion_orientation_unit import qou_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	qou_req_if.sink   req,
	qou_rsp_if.source rsp
);
	state_t state_q, state_nx;
	func_t  func_q;
	logic [1:0] axis_q;
	logic       pass_q;
	logic signed [QW-1:0] arg_q [4];
	logic signed [QW-1:0] quat_q [4];
	logic signed [QW-1:0] vec_q [3];

	logic signed [BW-1:0] cx_q, cy_q, cos_q;
	logic signed [ZW-1:0] cz_q;
	logic                 neg_q;
	logic [STEP_W-1:0]    step_q;

	logic signed [AW-1:0] a_q [4];
	logic signed [BW-1:0] b_q [4];
	logic signed [SW-1:0] r_q [3];
	logic signed [SW-1:0] sum_q;
	logic signed [PW-1:0] prod_q;
	logic [1:0] k_q, j_q, ph_q;

	logic accept, cordic_done, ham_done;
	logic signed [QW-1:0] theta_src;
	logic signed [ZW-1:0] theta, theta_red;
	logic                 theta_neg;
	logic signed [BW-1:0] dx, dy, cx_nx, cy_nx, xf, yf;
	logic signed [ZW-1:0] cz_nx;
	logic signed [AW-1:0] a_sel;
	logic signed [BW-1:0] b_sel;
	logic signed [MW-1:0] mul_a;
	logic signed [MW+BW-1:0] mul_p;
	logic signed [TW-1:0] term;
	logic signed [SW-1:0] sum_nx;
	logic signed [SW-1:0] r_fin [4];
	logic                 q_wr;
	logic signed [QW-1:0] q_nx [4];

	assign accept = req.valid && req.ready;
	assign cordic_done = (state_q == ST_CORDIC) && (step_q == STEP_W'(CORDIC_STEPS - 1));
	assign ham_done = (state_q == ST_HAM) && (ph_q == 2'd2) && (k_q == 2'd3) && (j_q == 2'd3);

	// angle reduction: Q4.28 doubled reads as the Q.30 half angle
	always_comb begin
		theta_src = (state_q == ST_IDLE) ? req.angle : arg_q[axis_q];
		theta = {{(ZW-QW-1){theta_src[QW-1]}}, theta_src, 1'b0};
		theta_neg = 1'b1;
		if (theta > HALF_PI_Q30)
			theta_red = theta - PI_Q30;
		else if (theta < -HALF_PI_Q30)
			theta_red = theta + PI_Q30;
		else begin
			theta_red = theta;
			theta_neg = 1'b0;
		end
	end

	always_comb begin
		dx = cy_q >>> step_q;
		dy = cx_q >>> step_q;
		if (!cz_q[ZW-1]) begin
			cx_nx = cx_q - dx;
			cy_nx = cy_q + dy;
			cz_nx = cz_q - atan_entry(step_q);
		end else begin
			cx_nx = cx_q + dx;
			cy_nx = cy_q - dy;
			cz_nx = cz_q + atan_entry(step_q);
		end
		xf = neg_q ? -cx_nx : cx_nx;
		yf = neg_q ? -cy_nx : cy_nx;
	end

	// shared multiplier: low half of a, then high half
	always_comb begin
		a_sel = a_q[j_q];
		b_sel = b_q[~k_q ^ j_q];
		if (ph_q == 2'd0)
			mul_a = {1'b0, a_sel[HW-1:0]};
		else
			mul_a = {a_sel[AW-1], a_sel[AW-1:HW]};
		mul_p = (MW+BW)'(mul_a) * (MW+BW)'(b_sel);
		term = TW'((prod_q + ROUND_HALF) >>> FRAC);
		if (HAM_MINUS[{k_q, j_q}])
			sum_nx = ((j_q == 2'd0) ? SW'(0) : sum_q) - SW'(term);
		else
			sum_nx = ((j_q == 2'd0) ? SW'(0) : sum_q) + SW'(term);
		for (int i = 0; i < 3; i++)
			r_fin[i] = r_q[i];
		r_fin[3] = sum_nx;
	end

	always_comb begin
		q_wr = ham_done && ((func_q == FUNC_LOAD) || (func_q == FUNC_APPLY));
		for (int i = 0; i < 4; i++)
			q_nx[i] = sat32(r_fin[i]);
		if (func_q == FUNC_LOAD)
			q_nx[3] = sat32(SW'(cos_q));
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (func_t'(req.func))
						FUNC_LOAD:  state_nx = ST_CORDIC;
						FUNC_APPLY: state_nx = ST_NEXT;
						FUNC_ROT:   state_nx = ST_HAM;
						default:    state_nx = ST_OUT;
					endcase
				end
			end
			ST_NEXT: begin
				if (axis_q == 2'd3)
					state_nx = ST_OUT;
				else if (arg_q[axis_q] != '0)
					state_nx = ST_CORDIC;
			end
			ST_CORDIC: begin
				if (cordic_done)
					state_nx = ST_HAM;
			end
			ST_HAM: begin
				if (ham_done) begin
					if (func_q == FUNC_ROT && !pass_q)
						state_nx = ST_HAM;
					else if (func_q == FUNC_APPLY)
						state_nx = ST_NEXT;
					else
						state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (rsp.ready)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == ST_IDLE);
		rsp.valid = (state_q == ST_OUT);
		rsp.quat_x = quat_q[0];
		rsp.quat_y = quat_q[1];
		rsp.quat_z = quat_q[2];
		rsp.quat_w = quat_q[3];
		rsp.vec_x = vec_q[0];
		rsp.vec_y = vec_q[1];
		rsp.vec_z = vec_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			quat_q[0] <= '0;
			quat_q[1] <= '0;
			quat_q[2] <= '0;
			quat_q[3] <= Q30_ONE;
		end else begin
			state_q <= state_nx;
			if (q_wr)
				quat_q <= q_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(req.func);
			arg_q[0] <= req.arg_x;
			arg_q[1] <= req.arg_y;
			arg_q[2] <= req.arg_z;
			arg_q[3] <= req.angle;
			axis_q <= 2'd0;
			pass_q <= 1'b0;
			k_q <= 2'd0;
			j_q <= 2'd0;
			ph_q <= 2'd0;
			for (int i = 0; i < 3; i++)
				vec_q[i] <= '0;
			for (int i = 0; i < 4; i++)
				a_q[i] <= AW'(quat_q[i]);
			b_q[0] <= BW'(req.arg_x);
			b_q[1] <= BW'(req.arg_y);
			b_q[2] <= BW'(req.arg_z);
			b_q[3] <= '0;
		end
		if (state_q == ST_IDLE || state_q == ST_NEXT) begin
			cx_q <= CORDIC_GAIN;
			cy_q <= '0;
			cz_q <= theta_red;
			neg_q <= theta_neg;
			step_q <= '0;
		end
		if (state_q == ST_NEXT && axis_q != 2'd3 && arg_q[axis_q] == '0)
			axis_q <= axis_q + 2'd1;
		if (state_q == ST_CORDIC) begin
			cx_q <= cx_nx;
			cy_q <= cy_nx;
			cz_q <= cz_nx;
			step_q <= step_q + STEP_W'(1);
			if (cordic_done) begin
				cos_q <= xf;
				if (func_q == FUNC_LOAD) begin
					for (int i = 0; i < 3; i++)
						a_q[i] <= AW'(arg_q[i]);
					a_q[3] <= '0;
					for (int i = 0; i < 3; i++)
						b_q[i] <= '0;
					b_q[3] <= yf;
				end else begin
					for (int i = 0; i < 4; i++)
						a_q[i] <= AW'(quat_q[i]);
					for (int i = 0; i < 3; i++)
						b_q[i] <= (axis_q == 2'(i)) ? yf : '0;
					b_q[3] <= xf;
				end
			end
		end
		if (state_q == ST_HAM) begin
			case (ph_q)
				2'd0: begin
					prod_q <= PW'(mul_p);
					ph_q <= 2'd1;
				end
				2'd1: begin
					prod_q <= prod_q + (PW'(mul_p) <<< HW);
					ph_q <= 2'd2;
				end
				default: begin
					ph_q <= 2'd0;
					sum_q <= sum_nx;
					j_q <= j_q + 2'd1;
					if (j_q == 2'd3) begin
						k_q <= k_q + 2'd1;
						if (k_q != 2'd3)
							r_q[k_q] <= sum_nx;
					end
				end
			endcase
			if (ham_done) begin
				if (func_q == FUNC_APPLY)
					axis_q <= axis_q + 2'd1;
				if (func_q == FUNC_ROT) begin
					if (!pass_q) begin
						pass_q <= 1'b1;
						for (int i = 0; i < 4; i++)
							a_q[i] <= AW'(r_fin[i]);
						for (int i = 0; i < 3; i++)
							b_q[i] <= -BW'(quat_q[i]);
						b_q[3] <= BW'(quat_q[3]);
					end else begin
						for (int i = 0; i < 3; i++)
							vec_q[i] <= sat32(r_fin[i]);
					end
				end
			end
		end
	end

	`QOU_ASSERT_IMPL(a_one_side, rsp.valid, !req.ready, "input taken while result pending")
	`QOU_ASSERT_NEXT(a_busy_after_accept, accept, !req.ready, "ready right after accept")
	`QOU_ASSERT_IMPL(a_vec_zero, rsp.valid && func_q != FUNC_ROT, vec_q[0] == '0 && vec_q[1] == '0 && vec_q[2] == '0, "vector nonzero outside rotate")
	`QOU_ASSERT_IMPL(a_ham_phase, state_q == ST_NEXT || state_q == ST_CORDIC || state_q == ST_OUT, ph_q == 2'd0 && j_q == 2'd0 && k_q == 2'd0, "product counters not at rest")
endmodule
